// ===== rtl/brcm_pkg.sv =====
`timescale 1ns / 1ps

package brcm_pkg;

   localparam int SYMBOL_WIDTH           = 16;
   localparam int WEIGHT_WIDTH           = 16;
   localparam int CFG_WIDTH              = 7;
   localparam int CSR_INDEX_WIDTH        = 2;
   localparam int MAX_SAMPLES_PER_SYMBOL = 64;
   localparam int SHAPE_TABLE_SIZE       = 64;
   localparam int SAMPLE_INDEX_WIDTH     = $clog2(MAX_SAMPLES_PER_SYMBOL);
   localparam int TABLE_INDEX_WIDTH      = $clog2(SHAPE_TABLE_SIZE);
   localparam int QUEUE_DEPTH            = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLES_PER_SYMBOL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_STEP         = 2'd1;

   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef struct packed {
      logic signed [SYMBOL_WIDTH-1:0]  symbol;
      logic [SAMPLE_INDEX_WIDTH-1:0]   last_index;
   } entry_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type head;
   } queue_status_type;

   typedef logic [WEIGHT_WIDTH-1:0] weight_array_type [SHAPE_TABLE_SIZE];

   function automatic logic [63:0] horner_step(input logic [63:0] p);
      return (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
   endfunction

   function automatic logic [63:0] cos_quarter(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = horner_step(((x2 * t) >> 30) / 64'd380);
      t  = horner_step(((x2 * t) >> 30) / 64'd306);
      t  = horner_step(((x2 * t) >> 30) / 64'd240);
      t  = horner_step(((x2 * t) >> 30) / 64'd182);
      t  = horner_step(((x2 * t) >> 30) / 64'd132);
      t  = horner_step(((x2 * t) >> 30) / 64'd90);
      t  = horner_step(((x2 * t) >> 30) / 64'd56);
      t  = horner_step(((x2 * t) >> 30) / 64'd30);
      t  = horner_step(((x2 * t) >> 30) / 64'd12);
      t  = horner_step(((x2 * t) >> 30) / 64'd2);
      return t;
   endfunction

   function automatic logic signed [63:0] shape_cos(input int k);
      logic [63:0] kk;
      logic [63:0] mag;
      logic        neg;
      kk  = 64'(k);
      neg = 1'b0;
      if (2 * k > SHAPE_TABLE_SIZE) begin
         kk  = 64'(SHAPE_TABLE_SIZE - k);
         neg = 1'b1;
      end
      mag = cos_quarter((PI_Q30 * kk) / SHAPE_TABLE_SIZE);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic weight_array_type build_wc();
      weight_array_type tbl;
      logic signed [63:0] c;
      logic [63:0]        a;
      logic [63:0]        v;
      for (int k = 0; k < SHAPE_TABLE_SIZE; k++) begin
         c = shape_cos(k);
         a = $unsigned($signed(Q30_ONE) - c);
         v = (a + 64'd16384) >> 15;
         tbl[k] = (v > 64'd65535) ? 16'hFFFF : v[WEIGHT_WIDTH-1:0];
      end
      return tbl;
   endfunction

   function automatic weight_array_type build_wp();
      weight_array_type tbl;
      logic signed [63:0] c;
      logic [63:0]        b;
      logic [63:0]        v;
      for (int k = 0; k < SHAPE_TABLE_SIZE; k++) begin
         c = shape_cos(k);
         b = $unsigned($signed(Q30_ONE) + c);
         v = (b * 64'd499 + 64'd16384000) / 64'd32768000;
         tbl[k] = (v > 64'd65535) ? 16'hFFFF : v[WEIGHT_WIDTH-1:0];
      end
      return tbl;
   endfunction

   localparam weight_array_type WC_TABLE = build_wc();
   localparam weight_array_type WP_TABLE = build_wp();

endpackage

// ===== rtl/bpsk_raised_cosine_modulator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// req       in         valid / stall    symbol_value (s16, Q1.14)
// rsp       out        valid / stall    in_phase (s16), quadrature (s16, zero), run_last
// csr       in         valid / ready    index (2), data (7)
//
// Each symbol yields samples_per_symbol samples (1 to 64) from the sample sequencer, one
// per cycle unless rsp_stall holds them; each goes via registers s1, s2 and out to rsp_valid.
// A two-entry queue separates intake from shaping, so req takes symbols while a run plays.
// Reset is synchronous; registers return to 8 samples and step 8, the prior symbol to zero.
// rsp_stall freezes the pipeline while rsp_valid is high; req_stall rises only when queue is full.

module bpsk_raised_cosine_modulator (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    req_symbol_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    rsp_in_phase,
   output logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    rsp_quadrature,
   output logic                                        rsp_run_last,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [brcm_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [brcm_pkg::CFG_WIDTH-1:0]              csr_data
);

   logic [brcm_pkg::CFG_WIDTH-1:0] samples_per_symbol_ff, samples_per_symbol_in;
   logic [brcm_pkg::CFG_WIDTH-1:0] phase_step_ff, phase_step_in;

   logic                        push;
   logic                        pop;
   brcm_pkg::entry_type         push_entry;
   brcm_pkg::queue_status_type  status;

   assign csr_ready = 1'b1;

   always_comb begin
      samples_per_symbol_in = samples_per_symbol_ff;
      phase_step_in         = phase_step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            brcm_pkg::CSR_SAMPLES_PER_SYMBOL: samples_per_symbol_in = csr_data;
            brcm_pkg::CSR_PHASE_STEP:         phase_step_in         = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_symbol_ff <= brcm_pkg::CFG_WIDTH'(8);
         phase_step_ff         <= brcm_pkg::CFG_WIDTH'(8);
      end else begin
         samples_per_symbol_ff <= samples_per_symbol_in;
         phase_step_ff         <= phase_step_in;
      end
   end

   brcm_front u_front (
      .req_valid          (req_valid),
      .req_symbol_value   (req_symbol_value),
      .samples_per_symbol (samples_per_symbol_ff),
      .queue_full         (status.full),
      .req_stall          (req_stall),
      .push               (push),
      .push_entry         (push_entry)
   );

   brcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (status)
   );

   brcm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .phase_step     (phase_step_ff),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_in_phase   (rsp_in_phase),
      .rsp_quadrature (rsp_quadrature),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// ===== rtl/brcm_front.sv =====
`timescale 1ns / 1ps

module brcm_front (
   input  logic                                        req_valid,
   input  logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    req_symbol_value,
   input  logic [brcm_pkg::CFG_WIDTH-1:0]              samples_per_symbol,
   input  logic                                        queue_full,
   output logic                                        req_stall,
   output logic                                        push,
   output brcm_pkg::entry_type                         push_entry
);

   localparam logic [brcm_pkg::CFG_WIDTH-1:0] MAX_LEN =
      brcm_pkg::CFG_WIDTH'(brcm_pkg::MAX_SAMPLES_PER_SYMBOL);

   logic [brcm_pkg::CFG_WIDTH-1:0] len;
   logic [brcm_pkg::CFG_WIDTH-1:0] last;

   always_comb begin
      len = samples_per_symbol;
      if (len == '0) begin
         len = brcm_pkg::CFG_WIDTH'(1);
      end
      if (len > MAX_LEN) begin
         len = MAX_LEN;
      end
      last = len - brcm_pkg::CFG_WIDTH'(1);
   end

   assign req_stall             = queue_full;
   assign push                  = req_valid && !queue_full;
   assign push_entry.symbol     = req_symbol_value;
   assign push_entry.last_index = last[brcm_pkg::SAMPLE_INDEX_WIDTH-1:0];

endmodule

// ===== rtl/brcm_queue.sv =====
`timescale 1ns / 1ps

module brcm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  brcm_pkg::entry_type           push_entry,
   input  logic                          pop,
   output brcm_pkg::queue_status_type    status
);

   localparam int PTR_WIDTH = (brcm_pkg::QUEUE_DEPTH > 1) ? $clog2(brcm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(brcm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(brcm_pkg::QUEUE_DEPTH - 1);

   brcm_pkg::entry_type  mem_ff [brcm_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_WIDTH'(brcm_pkg::QUEUE_DEPTH));
   assign status.head  = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(brcm_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/brcm_back.sv =====
`timescale 1ns / 1ps

module brcm_back (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [brcm_pkg::CFG_WIDTH-1:0]              phase_step,
   input  brcm_pkg::queue_status_type                  status,
   output logic                                        pop,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    rsp_in_phase,
   output logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]    rsp_quadrature,
   output logic                                        rsp_run_last
);

   localparam int SW  = brcm_pkg::SYMBOL_WIDTH;
   localparam int WW  = brcm_pkg::WEIGHT_WIDTH;
   localparam int JW  = brcm_pkg::SAMPLE_INDEX_WIDTH;
   localparam int TW  = brcm_pkg::TABLE_INDEX_WIDTH;
   localparam int KW  = JW + brcm_pkg::CFG_WIDTH;
   localparam int PW  = SW + WW + 1;
   localparam int AW  = PW + 1;
   localparam int RW  = AW + 1;
   localparam logic [KW-1:0] K_MAX = KW'(brcm_pkg::SHAPE_TABLE_SIZE - 1);
   localparam logic signed [RW-1:0] ROUND = RW'(1) <<< (WW - 1);
   localparam logic signed [RW-1:0] SAT_HI = RW'(2 ** (SW - 1) - 1);
   localparam logic signed [RW-1:0] SAT_LO = -RW'(2 ** (SW - 1));

   logic          adv;
   logic          issue;
   logic          last;
   logic [KW-1:0] k_full;
   logic [TW-1:0] k_idx;

   logic [JW-1:0]          j_ff, j_in;
   logic signed [SW-1:0]   prev_ff, prev_in;

   logic                   s1_valid_ff;
   logic signed [SW-1:0]   s1_cur_ff, s1_prev_ff;
   logic [WW-1:0]          s1_wc_ff, s1_wp_ff;
   logic                   s1_last_ff;

   logic                   s2_valid_ff;
   logic signed [PW-1:0]   s2_pc_ff, s2_pp_ff;
   logic                   s2_last_ff;

   logic signed [RW-1:0]   sum;
   logic signed [RW-1:0]   rounded;
   logic signed [SW-1:0]   sat;

   logic                   out_valid_ff;
   logic signed [SW-1:0]   out_i_ff;
   logic                   out_last_ff;

   assign adv    = !out_valid_ff || !rsp_stall;
   assign issue  = adv && !status.empty;
   assign last   = (j_ff == status.head.last_index);
   assign pop    = issue && last;
   assign k_full = KW'(j_ff) * KW'(phase_step);
   assign k_idx  = (k_full > K_MAX) ? K_MAX[TW-1:0] : k_full[TW-1:0];

   always_comb begin
      j_in    = j_ff;
      prev_in = prev_ff;
      if (issue) begin
         j_in = last ? '0 : j_ff + JW'(1);
      end
      if (pop) begin
         prev_in = status.head.symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         j_ff    <= j_in;
         prev_ff <= prev_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_comb begin
      sum     = RW'(s2_pc_ff) + RW'(s2_pp_ff);
      rounded = (sum + ROUND) >>> WW;
      if (rounded > SAT_HI) begin
         sat = SAT_HI[SW-1:0];
      end else if (rounded < SAT_LO) begin
         sat = SAT_LO[SW-1:0];
      end else begin
         sat = rounded[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cur_ff   <= status.head.symbol;
         s1_prev_ff  <= prev_ff;
         s1_wc_ff    <= brcm_pkg::WC_TABLE[k_idx];
         s1_wp_ff    <= brcm_pkg::WP_TABLE[k_idx];
         s1_last_ff  <= last;
         s2_pc_ff    <= PW'(s1_cur_ff) * PW'($signed({1'b0, s1_wc_ff}));
         s2_pp_ff    <= PW'(s1_prev_ff) * PW'($signed({1'b0, s1_wp_ff}));
         s2_last_ff  <= s1_last_ff;
         out_i_ff    <= sat;
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_in_phase   = out_i_ff;
   assign rsp_quadrature = '0;
   assign rsp_run_last   = out_last_ff;

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> j_ff <= status.head.last_index)
      else $error("sample index past end of run");

   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> j_ff == '0)
      else $error("sample index not cleared between runs");

   a_stage_follow: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_valid_ff == $past(s2_valid_ff))
      else $error("output stage lost track of pipeline");

   a_prev_update: assert property (@(posedge clock) disable iff (reset)
      !pop |=> prev_ff == $past(prev_ff))
      else $error("previous symbol changed outside end of run");

endmodule

// ===== verif/brcm_sample_checker.sv =====
`timescale 1ns / 1ps

module brcm_sample_checker (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  logic                                       req_stall,
   input  logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]   req_symbol_value,
   input  logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   input  logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]   rsp_in_phase,
   input  logic signed [brcm_pkg::SYMBOL_WIDTH-1:0]   rsp_quadrature,
   input  logic                                       rsp_run_last,
   input  logic                                       csr_valid,
   input  logic                                       csr_ready,
   input  logic [brcm_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [brcm_pkg::CFG_WIDTH-1:0]             csr_data,
   output int                                         fail_count,
   output int                                         pending
);
   import brcm_pkg::*;

   localparam longint unsigned Q30_UNIT = 64'd1073741824;
   localparam longint unsigned Q30_PI   = 64'd3373259426;

   typedef struct {
      logic signed [SYMBOL_WIDTH-1:0] in_phase;
      logic signed [SYMBOL_WIDTH-1:0] quadrature;
      logic                           run_last;
   } shaped_sample_type;

   shaped_sample_type            expected_samples[$];
   logic [CFG_WIDTH-1:0]         run_length;
   logic [CFG_WIDTH-1:0]         table_step;
   logic signed [SYMBOL_WIDTH-1:0] prior_symbol;

   initial begin
      fail_count   = 0;
      pending      = 0;
      run_length   = 7'd8;
      table_step   = 7'd8;
      prior_symbol = '0;
   end

   // signed Q2.30 cosine of pi*k/SHAPE_TABLE_SIZE, Taylor series through x^20
   function automatic longint shape_cosine(input int k);
      longint unsigned kk;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned p;
      bit              neg;
      kk  = longint'(k);
      neg = 1'b0;
      if (2 * k > SHAPE_TABLE_SIZE) begin
         kk  = longint'(SHAPE_TABLE_SIZE - k);
         neg = 1'b1;
      end
      x  = (Q30_PI * kk) / SHAPE_TABLE_SIZE;
      x2 = (x * x) >> 30;
      t  = Q30_UNIT;
      for (int n = 20; n >= 2; n -= 2) begin
         p = ((x2 * t) >> 30) / longint'(n * (n - 1));
         t = (p > Q30_UNIT) ? 64'd0 : Q30_UNIT - p;
      end
      return neg ? -longint'(t) : longint'(t);
   endfunction

   task automatic shape_symbol(input logic signed [SYMBOL_WIDTH-1:0] sym);
      shaped_sample_type s;
      int             len;
      int             k;
      longint         c;
      longint         wc;
      longint         wp;
      longint         acc;
      longint         r;
      len = int'(run_length);
      if (len == 0) len = 1;
      if (len > MAX_SAMPLES_PER_SYMBOL) len = MAX_SAMPLES_PER_SYMBOL;
      for (int j = 0; j < len; j++) begin
         k = j * int'(table_step);
         if (k > SHAPE_TABLE_SIZE - 1) k = SHAPE_TABLE_SIZE - 1;
         c  = shape_cosine(k);
         wc = (longint'(Q30_UNIT) - c + 16384) >>> 15;
         wp = ((longint'(Q30_UNIT) + c) * 499 + 16384000) / 32768000;
         if (wc > 65535) wc = 65535;
         if (wp > 65535) wp = 65535;
         acc = longint'(sym) * wc + longint'(prior_symbol) * wp;
         r   = (acc + 32768) >>> 16;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         s.in_phase   = r[SYMBOL_WIDTH-1:0];
         s.quadrature = '0;
         s.run_last   = (j == len - 1);
         expected_samples.push_back(s);
      end
      prior_symbol = sym;
   endtask

   task automatic check_sample();
      shaped_sample_type want;
      if (expected_samples.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected sample: in_phase %0d quadrature %0d run_last %0b",
                     rsp_in_phase, rsp_quadrature, rsp_run_last);
      end else begin
         want = expected_samples.pop_front();
         if (rsp_in_phase !== want.in_phase || rsp_quadrature !== want.quadrature ||
             rsp_run_last !== want.run_last) begin
            fail_count++;
            if (fail_count <= 10)
               $display("sample mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        want.in_phase, want.quadrature, want.run_last,
                        rsp_in_phase, rsp_quadrature, rsp_run_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_length   = 7'd8;
         table_step   = 7'd8;
         prior_symbol = '0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_sample();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLES_PER_SYMBOL: run_length = csr_data;
               CSR_PHASE_STEP:         table_step = csr_data;
               default:                ;
            endcase
         end
         if (req_valid && !req_stall)
            shape_symbol(req_symbol_value);
      end
      pending <= expected_samples.size();
   end

endmodule

// ===== verif/bpsk_raised_cosine_modulator_tb.sv =====
`timescale 1ns / 1ps

module bpsk_raised_cosine_modulator_tb;
   import brcm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic signed [SYMBOL_WIDTH-1:0] OPENING_SYMBOLS [15] = '{
      16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384,
      16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sh8000,
      16'sd1, -16'sd1, 16'sd0, 16'sh5555, 16'shAAAA
   };

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic signed [SYMBOL_WIDTH-1:0]  req_symbol_value;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic signed [SYMBOL_WIDTH-1:0]  rsp_in_phase;
   logic signed [SYMBOL_WIDTH-1:0]  rsp_quadrature;
   logic                            rsp_run_last;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]      csr_index;
   logic [CFG_WIDTH-1:0]            csr_data;
   logic                            calm;
   int                              fail_count;
   int                              pending;
   int                              cycles;

   bpsk_raised_cosine_modulator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol_value (req_symbol_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_in_phase     (rsp_in_phase),
      .rsp_quadrature   (rsp_quadrature),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   brcm_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol_value (req_symbol_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_in_phase     (rsp_in_phase),
      .rsp_quadrature   (rsp_quadrature),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[bpsk_raised_cosine_modulator] ERROR");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= !calm && ($urandom_range(99) < 7);
      end
   end

   function automatic logic signed [SYMBOL_WIDTH-1:0] pick_symbol();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6)
         return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      else if (roll == 6)
         return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else
         return SYMBOL_WIDTH'($urandom);
   endfunction

   task automatic send_symbol(input logic signed [SYMBOL_WIDTH-1:0] sym);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid        <= 1'b0;
         req_symbol_value <= SYMBOL_WIDTH'($urandom);
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_symbol_value <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // drain, let the pipeline settle, then reprogram
   task automatic set_shape(input logic [CFG_WIDTH-1:0] spsym,
                            input logic [CFG_WIDTH-1:0] step);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_csr(CSR_SAMPLES_PER_SYMBOL, spsym);
      if ($urandom_range(2) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3, CFG_WIDTH'($urandom));
      write_csr(CSR_PHASE_STEP, step);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CFG_WIDTH-1:0] spsym;
      logic [CFG_WIDTH-1:0] step;
      reset            = 1'b1;
      calm             = 1'b0;
      req_valid        = 1'b0;
      req_symbol_value = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_SYMBOLS[i])
         send_symbol(OPENING_SYMBOLS[i]);

      set_shape(7'd1, 7'd1);
      repeat (6) send_symbol(pick_symbol());
      set_shape(7'd64, 7'd64);
      repeat (6) send_symbol(pick_symbol());
      set_shape(7'd0, 7'd0);
      repeat (6) send_symbol(pick_symbol());
      set_shape(7'd127, 7'd127);
      repeat (6) send_symbol(pick_symbol());
      set_shape(7'd64, 7'd1);
      repeat (6) send_symbol(pick_symbol());

      for (int phase = 0; phase < 10; phase++) begin
         if ($urandom_range(4) == 0)
            spsym = CFG_WIDTH'($urandom_range(127));
         else
            spsym = CFG_WIDTH'($urandom_range(1, 16));
         case ($urandom_range(2))
            0:       step = CFG_WIDTH'($urandom_range(127));
            1:       step = (spsym != 0) ? CFG_WIDTH'(64 / spsym) : 7'd64;
            default: step = CFG_WIDTH'($urandom_range(1, 16));
         endcase
         set_shape(spsym, step);
         calm = (phase == 3);
         for (int n = 0; n < 24; n++) begin
            if (phase == 5 && n == 12)
               hold_until_drained();
            send_symbol(pick_symbol());
         end
         calm = 1'b0;
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[bpsk_raised_cosine_modulator] OK");
      else
         $display("[bpsk_raised_cosine_modulator] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/brcm_pkg.sv
rtl/brcm_front.sv
rtl/brcm_queue.sv
rtl/brcm_back.sv
rtl/bpsk_raised_cosine_modulator.sv
verif/brcm_sample_checker.sv
verif/bpsk_raised_cosine_modulator_tb.sv
